FILE: rtl/core/qdc_pkg.sv
// Shared types, constants and position arithmetic for the quadrature detent counter.
package qdc_pkg;

	// Display position is held as a sign and four BCD digits, most significant digit at the highest index.
	localparam int unsigned DIGITS = 4;

	typedef logic [3:0] bcd_t;
	typedef bcd_t [DIGITS-1:0] mag_t;

	typedef struct packed {
		logic neg;
		mag_t dig;
	} pos_t;

	typedef enum logic [1:0] {
		DIR_NONE,
		DIR_CW,
		DIR_CCW
	} dir_t;

	localparam logic [7:0] CMD_PREFIX = 8'd254;
	localparam logic [7:0] CMD_HOME   = 8'd128;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_MINUS = 8'h2d;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;

	localparam logic [3:0] DETENT_RESET = 4'd4;

	// Fixed head of every burst: prefix, home, four spaces, prefix, home.
	localparam logic [3:0] HEAD_LEN = 4'd8;

	localparam bcd_t BCD_NINE = 4'd9;
	localparam mag_t MAG_ZERO = '0;
	localparam mag_t MAG_POS_MAX = {BCD_NINE, BCD_NINE, BCD_NINE, BCD_NINE};
	localparam mag_t MAG_NEG_MAX = {4'd0, BCD_NINE, BCD_NINE, BCD_NINE};

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	// Position of a phase along the Gray sequence 00, 01, 11, 10.
	function automatic logic [1:0] gray_index(logic [1:0] p);
		return {p[1], p[1] ^ p[0]};
	endfunction

	function automatic dir_t step_dir(logic [1:0] old_p, logic [1:0] new_p);
		logic [1:0] io;
		logic [1:0] in;
		io = gray_index(old_p);
		in = gray_index(new_p);
		if (in == io + 2'd1)
			return DIR_CW;
		else if (io == in + 2'd1)
			return DIR_CCW;
		else
			return DIR_NONE;
	endfunction

	function automatic mag_t mag_inc(mag_t m);
		mag_t r;
		logic carry;
		r = m;
		carry = 1'b1;
		for (int i = 0; i < DIGITS; i++) begin
			if (carry) begin
				if (m[i] == BCD_NINE) begin
					r[i] = 4'd0;
				end else begin
					r[i] = m[i] + 4'd1;
					carry = 1'b0;
				end
			end
		end
		return r;
	endfunction

	function automatic mag_t mag_dec(mag_t m);
		mag_t r;
		logic borrow;
		r = m;
		borrow = 1'b1;
		for (int i = 0; i < DIGITS; i++) begin
			if (borrow) begin
				if (m[i] == 4'd0) begin
					r[i] = BCD_NINE;
				end else begin
					r[i] = m[i] - 4'd1;
					borrow = 1'b0;
				end
			end
		end
		return r;
	endfunction

	// One count clockwise, holding at +9999.
	function automatic pos_t pos_up(pos_t p);
		pos_t r;
		r = p;
		if (p.neg) begin
			r.dig = mag_dec(p.dig);
			r.neg = (r.dig != MAG_ZERO);
		end else if (p.dig != MAG_POS_MAX) begin
			r.dig = mag_inc(p.dig);
		end
		return r;
	endfunction

	// One count counter-clockwise, holding at -999.
	function automatic pos_t pos_down(pos_t p);
		pos_t r;
		r = p;
		if (!p.neg) begin
			if (p.dig == MAG_ZERO) begin
				r.neg = 1'b1;
				r.dig = mag_inc(MAG_ZERO);
			end else begin
				r.dig = mag_dec(p.dig);
			end
		end else if (p.dig != MAG_NEG_MAX) begin
			r.dig = mag_inc(p.dig);
		end
		return r;
	endfunction

	// Number of printed digits, without leading zeros; zero prints as one digit.
	function automatic logic [2:0] digit_count(mag_t m);
		if (m[3] != 4'd0)
			return 3'd4;
		else if (m[2] != 4'd0)
			return 3'd3;
		else if (m[1] != 4'd0)
			return 3'd2;
		else
			return 3'd1;
	endfunction

endpackage

FILE: rtl/core/qdc_front.sv
// Front end: decodes encoder phases, counts detent runs and tracks the display position.
module qdc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [3:0]         detent_steps,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               phase_a,
	input  logic               phase_b,
	input  logic               full,
	output logic               push,
	output qdc_pkg::pos_t      push_data
);

	logic [1:0]    last_phase_q;
	logic [3:0]    cw_run_q;
	logic [3:0]    ccw_run_q;
	qdc_pkg::pos_t pos_q;

	logic [1:0]    phase;
	qdc_pkg::dir_t dir;
	logic [3:0]    cw_next;
	logic [3:0]    ccw_next;
	logic          cw_done;
	logic          ccw_done;
	logic          accept;

	// Items that finish no detent would not need queue space, but a simple
	// full check keeps the ready path short.
	assign in_ready = !full;
	assign accept   = in_valid && in_ready;

	assign phase    = {phase_a, phase_b};
	assign dir      = qdc_pkg::step_dir(last_phase_q, phase);
	assign cw_next  = cw_run_q + 4'd1;
	assign ccw_next = ccw_run_q + 4'd1;
	assign cw_done  = (dir == qdc_pkg::DIR_CW) && (cw_next >= detent_steps);
	assign ccw_done = (dir == qdc_pkg::DIR_CCW) && (ccw_next >= detent_steps);

	assign push      = accept && (cw_done || ccw_done);
	assign push_data = cw_done ? qdc_pkg::pos_up(pos_q) : qdc_pkg::pos_down(pos_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_phase_q <= '0;
			cw_run_q     <= '0;
			ccw_run_q    <= '0;
			pos_q        <= '0;
		end else if (accept) begin
			last_phase_q <= phase;
			unique case (dir)
				qdc_pkg::DIR_CW: begin
					ccw_run_q <= '0;
					cw_run_q  <= cw_done ? 4'd0 : cw_next;
				end
				qdc_pkg::DIR_CCW: begin
					cw_run_q  <= '0;
					ccw_run_q <= ccw_done ? 4'd0 : ccw_next;
				end
				default: begin
				end
			endcase
			if (cw_done || ccw_done)
				pos_q <= push_data;
		end
	end

endmodule

FILE: rtl/core/qdc_queue.sv
// Small queue of updated positions between the decoder and the burst generator.
module qdc_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  qdc_pkg::pos_t push_data,
	input  logic          pop,
	output qdc_pkg::pos_t pop_data,
	output logic          full,
	output logic          empty
);

	qdc_pkg::pos_t                mem_q [qdc_pkg::QDEPTH];
	logic [qdc_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [qdc_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [qdc_pkg::QCNT_W-1:0]   count_q;

	assign full     = (count_q == qdc_pkg::QCNT_W'(qdc_pkg::QDEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + qdc_pkg::QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + qdc_pkg::QPTR_W'(1);
			if (push && !pop)
				count_q <= count_q + qdc_pkg::QCNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - qdc_pkg::QCNT_W'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue read while empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= qdc_pkg::QCNT_W'(qdc_pkg::QDEPTH))
		else $error("queue count beyond depth");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + qdc_pkg::QCNT_W'(1))
		else $error("queue count missed a write");

endmodule

FILE: rtl/core/qdc_burst.sv
// Back end: turns a queued position into the LCD byte burst, one byte per cycle while out_ready is high.
module qdc_burst (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          empty,
	input  qdc_pkg::pos_t pop_data,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    lcd_byte,
	output logic          last_byte
);

	logic          busy_q;
	qdc_pkg::pos_t cur_q;
	logic [3:0]    idx_q;
	logic          valid_q;
	logic [7:0]    byte_q;
	logic          last_q;

	logic          advance;
	logic [2:0]    nd;
	logic [3:0]    last_idx;
	logic [2:0]    j;
	logic [2:0]    m;
	logic [2:0]    sel;
	logic [7:0]    next_byte;
	logic          next_last;

	assign advance = !valid_q || out_ready;
	assign pop     = !busy_q && !empty;

	assign nd        = qdc_pkg::digit_count(cur_q.dig);
	assign last_idx  = qdc_pkg::HEAD_LEN + {3'b0, cur_q.neg} + {1'b0, nd} - 4'd1;
	assign next_last = (idx_q == last_idx);
	assign j         = idx_q[2:0];
	assign m         = j - {2'b0, cur_q.neg};
	assign sel       = nd - 3'd1 - m;

	always_comb begin
		if (!idx_q[3]) begin
			unique case (idx_q[2:0])
				3'd0, 3'd6: next_byte = qdc_pkg::CMD_PREFIX;
				3'd1, 3'd7: next_byte = qdc_pkg::CMD_HOME;
				default:    next_byte = qdc_pkg::CHAR_SPACE;
			endcase
		end else if (cur_q.neg && (j == 3'd0)) begin
			next_byte = qdc_pkg::CHAR_MINUS;
		end else begin
			next_byte = qdc_pkg::CHAR_ZERO + {4'b0, cur_q.dig[sel[1:0]]};
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= pop_data;
		if (advance && busy_q) begin
			byte_q <= next_byte;
			last_q <= next_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (advance) begin
				valid_q <= busy_q;
				if (busy_q) begin
					idx_q <= idx_q + 4'd1;
					if (next_last)
						busy_q <= 1'b0;
				end
			end
			if (pop) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end
		end
	end

	assign out_valid = valid_q;
	assign lcd_byte  = byte_q;
	assign last_byte = last_q;

endmodule

FILE: rtl/core/quadrature_detent_counter_lcd_unit.sv
// Top level of the quadrature detent counter with serial LCD burst output.
//
// Input channel (in_valid/in_ready, phase_a, phase_b): one word is one sample of the
// two encoder channels. Valid transitions are sorted into clockwise and counter-clockwise
// runs; when a run reaches detent_steps the position (held between -999 and 9999) moves
// by one and a display burst is queued. Other samples only update the stored phase.
// Output channel (out_valid/out_ready, lcd_byte, last_byte): each burst is 9 to 12 words:
// prefix, home, four spaces, prefix, home, then the signed decimal position, with
// last_byte high on its final word.
// Throughput: a sample is taken every cycle while the position queue has room; the
// queue holds four pending bursts. The burst generator sends one word per cycle while
// out_ready is high, and it picks up the next queued position only once the last word
// of a burst has been registered.
// A position that completes a detent passes through the queue and the current-position
// register of the burst generator before its first word is registered at the output.
// A stalled receiver holds the output word; the front keeps accepting samples until the
// queue fills, then drops in_ready. Reset clears the phase, runs, position, queue and
// output, and sets detent_steps to 4. Configuration is an APB port with one register,
// detent_steps, at address 0.
module quadrature_detent_counter_lcd_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        phase_a,
	input  logic        phase_b,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  lcd_byte,
	output logic        last_byte
);

	// Register index taken from the word address.
	localparam logic REG_DETENT = 1'b0;

	logic [3:0]    detent_q;
	logic          cfg_write;

	logic          push;
	logic          pop;
	logic          full;
	logic          empty;
	qdc_pkg::pos_t push_data;
	qdc_pkg::pos_t pop_data;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata    = (paddr[2] == REG_DETENT) ? {28'b0, detent_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			detent_q <= qdc_pkg::DETENT_RESET;
		end else if (cfg_write && (paddr[2] == REG_DETENT)) begin
			detent_q <= pwdata[3:0];
		end
	end

	// Decoder and position tracker; pushes a new position for each completed detent.
	qdc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.detent_steps (detent_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.phase_a      (phase_a),
		.phase_b      (phase_b),
		.full         (full),
		.push         (push),
		.push_data    (push_data)
	);

	// Decouples the sample rate from the byte-serial display traffic.
	qdc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (full),
		.empty     (empty)
	);

	// Formats each queued position into its LCD burst.
	qdc_burst u_burst (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.pop_data  (pop_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.lcd_byte  (lcd_byte),
		.last_byte (last_byte)
	);

endmodule

FILE: tb/qdc_tb_pkg.sv
// Scoreboard class for the quadrature detent counter: detent prediction and LCD word checking.
`timescale 1ns / 1ps

package qdc_tb_pkg;

	// Previous phase in the high two bits, new phase in the low two bits.
	localparam logic [3:0] TR_11_01 = 4'd13;
	localparam logic [3:0] TR_01_00 = 4'd4;
	localparam logic [3:0] TR_00_10 = 4'd2;
	localparam logic [3:0] TR_10_11 = 4'd11;
	localparam logic [3:0] TR_11_10 = 4'd14;
	localparam logic [3:0] TR_01_11 = 4'd7;
	localparam logic [3:0] TR_00_01 = 4'd1;
	localparam logic [3:0] TR_10_00 = 4'd8;

	localparam int POS_CEIL  = 9999;
	localparam int POS_FLOOR = -999;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} lcd_word_t;

	class lcd_burst_scoreboard;
		logic [3:0] detent;
		logic [1:0] prev_phase;
		logic [3:0] cw_count;
		logic [3:0] ccw_count;
		int         position;
		lcd_word_t  pending[$];
		int         errors;

		function new();
			detent = qdc_pkg::DETENT_RESET;
			prev_phase = 2'b00;
			cw_count = '0;
			ccw_count = '0;
			position = 0;
			errors = 0;
		endfunction

		function void set_detent(logic [3:0] v);
			detent = v;
		endfunction

		function bit drained();
			return pending.size() == 0;
		endfunction

		function qdc_pkg::dir_t classify(logic [3:0] code);
			case (code)
				TR_11_01, TR_01_00, TR_00_10, TR_10_11: return qdc_pkg::DIR_CCW;
				TR_11_10, TR_01_11, TR_00_01, TR_10_00: return qdc_pkg::DIR_CW;
				default: return qdc_pkg::DIR_NONE;
			endcase
		endfunction

		// Advances the detent state by one sample and queues the burst it causes, if any.
		function void note_sample(logic [1:0] p);
			logic [3:0]    code;
			qdc_pkg::dir_t dir;
			bit            moved;
			int            mag;
			logic [7:0]    burst[$];
			code = {prev_phase, p};
			prev_phase = p;
			dir = classify(code);
			moved = 1'b0;
			case (dir)
				qdc_pkg::DIR_CCW: begin
					ccw_count = ccw_count + 4'd1;
					cw_count = '0;
					if (ccw_count >= detent) begin
						ccw_count = '0;
						if (position > POS_FLOOR)
							position--;
						moved = 1'b1;
					end
				end
				qdc_pkg::DIR_CW: begin
					cw_count = cw_count + 4'd1;
					ccw_count = '0;
					if (cw_count >= detent) begin
						cw_count = '0;
						if (position < POS_CEIL)
							position++;
						moved = 1'b1;
					end
				end
				default: ;
			endcase
			if (moved) begin
				burst = '{qdc_pkg::CMD_PREFIX, qdc_pkg::CMD_HOME, qdc_pkg::CHAR_SPACE,
					qdc_pkg::CHAR_SPACE, qdc_pkg::CHAR_SPACE, qdc_pkg::CHAR_SPACE,
					qdc_pkg::CMD_PREFIX, qdc_pkg::CMD_HOME};
				if (position < 0)
					burst.push_back(qdc_pkg::CHAR_MINUS);
				mag = (position < 0) ? -position : position;
				// Digits come least significant first, so each one goes in front of the
				// digits already placed.
				do begin
					burst.insert((position < 0) ? 9 : 8, 8'(qdc_pkg::CHAR_ZERO + mag % 10));
					mag = mag / 10;
				end while (mag != 0);
				foreach (burst[i])
					pending.push_back('{data: burst[i], last: (i == burst.size() - 1)});
			end
		endfunction

		function void check_word(logic [7:0] data, logic last);
			lcd_word_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected word: expected none, actual byte %0d last %0b",
					$time, data, last);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (data !== want.data) begin
				$display("%0t: lcd_byte mismatch: expected %0d, actual %0d",
					$time, want.data, data);
				errors++;
			end
			if (last !== want.last) begin
				$display("%0t: last_byte mismatch: expected %0b, actual %0b",
					$time, want.last, last);
				errors++;
			end
		endfunction
	endclass

endpackage

FILE: tb/quadrature_detent_counter_lcd_unit_tb.sv
// Top-level testbench of the quadrature detent counter with serial LCD output.
`timescale 1ns / 1ps

module quadrature_detent_counter_lcd_unit_tb;

	// Register map: detent_steps is the only register, at byte address 0.
	localparam logic [2:0] DETENT_ADDR = 3'd0;
	// Cycles to let pass after the last expected word before the block counts as idle.
	// A burst's first word follows its sample through the queue and the burst generator's registers, so this is ample.
	localparam int SETTLE_CYCLES = 20;
	// Cycles without any accepted word or register access before the run is abandoned.
	localparam int WATCHDOG_LIMIT = 4000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        phase_a = 1'b0;
	logic        phase_b = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  lcd_byte;
	logic        last_byte;

	qdc_tb_pkg::lcd_burst_scoreboard sb;

	// Phase that the sender last handed over, the direction of its random walk, and a
	// flag that switches idling off on both sides.
	logic [1:0] cur_phase = 2'b00;
	bit         spin_cw = 1'b1;
	bit         calm = 1'b0;
	int         stall_cycles = 0;

	// Opening sequence from phase 00 with detent_steps at its reset value of four: a full
	// clockwise detent, a repeated sample, two samples that flip both channels, two
	// counter-clockwise detents that cross zero, a reversal that clears both runs, and a
	// clockwise run of three left open for the lowered register below.
	logic [1:0] head_seq[20] = '{
		2'b01, 2'b11, 2'b10, 2'b00,
		2'b00, 2'b11, 2'b00,
		2'b10, 2'b11, 2'b01, 2'b00,
		2'b10, 2'b11, 2'b01, 2'b00,
		2'b01, 2'b00,
		2'b01, 2'b11, 2'b10
	};

	quadrature_detent_counter_lcd_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.phase_a(phase_a),
		.phase_b(phase_b),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.lcd_byte(lcd_byte),
		.last_byte(last_byte)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// The receiver stalls at random, about six percent of the time, except while calm is set.
	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= 6);
	end

	// Every word the block hands over is checked against the oldest expected word.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_word(lcd_byte, last_byte);
	end

	// The watchdog restarts on any accepted word or register access.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Next phase one step along the Gray sequence 00, 01, 11, 10 in either direction.
	function automatic logic [1:0] gray_step(input logic [1:0] p, input bit cw);
		case (p)
			2'b00: return cw ? 2'b01 : 2'b10;
			2'b01: return cw ? 2'b11 : 2'b00;
			2'b11: return cw ? 2'b10 : 2'b01;
			default: return cw ? 2'b00 : 2'b11;
		endcase
	endfunction

	// Hands one sample word to the block. It is called just after a rising edge, and it
	// returns at the edge that accepted the word, with valid still high so that a
	// following word can go out back to back.
	task automatic send_phase(input logic [1:0] p);
		if (!calm && $urandom_range(99) < 6) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		phase_a <= p[1];
		phase_b <= p[0];
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_sample(p);
		cur_phase = p;
	endtask

	// Stops the sender and waits until every expected word has come out; samples that
	// cause no burst may still be in flight, so a few more cycles go by after that.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (!sb.drained()) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes detent_steps over the configuration port, then reads it back.
	task automatic write_detent(input logic [3:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= DETENT_ADDR;
		pwdata <= {28'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== {28'd0, v}) begin
			$display("%0t: detent_steps read mismatch: expected %0d, actual %0d",
				$time, v, prdata);
			sb.errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		sb.set_detent(v);
	endtask

	// Random samples: mostly single Gray steps along a walk that changes direction now
	// and then, with some repeated samples and some that flip both channels.
	task automatic run_random(input int n_items);
		int         r;
		logic [1:0] nxt;
		for (int i = 0; i < n_items; i++) begin
			r = $urandom_range(99);
			if (r < 5) begin
				nxt = ~cur_phase;
			end else if (r < 12) begin
				nxt = cur_phase;
			end else begin
				if ($urandom_range(99) < 4)
					spin_cw = !spin_cw;
				nxt = gray_step(cur_phase, spin_cw);
			end
			send_phase(nxt);
		end
	endtask

	initial begin
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with the register at its reset value.
		foreach (head_seq[i])
			send_phase(head_seq[i]);

		// Lowering the register to two while the clockwise run stands at three makes the
		// next clockwise step complete a detent at once.
		wait_idle();
		write_detent(4'd2);
		send_phase(2'b00);

		// With a detent of zero every valid transition moves the position.
		wait_idle();
		write_detent(4'd0);
		send_phase(2'b01);
		send_phase(2'b00);
		send_phase(2'b00);

		// Random part over several settings, the extremes among them.
		wait_idle();
		write_detent(4'd15);
		run_random(60);

		// Halfway through this setting the sender holds off until the block has drained.
		wait_idle();
		write_detent(4'd1);
		run_random(30);
		in_valid <= 1'b0;
		while (!sb.drained()) @(posedge clk);
		@(posedge clk);
		run_random(30);

		// A stretch with no idling on either side.
		wait_idle();
		write_detent(4'd7);
		calm = 1'b1;
		run_random(60);
		calm = 1'b0;

		wait_idle();
		write_detent(4'd0);
		run_random(40);

		wait_idle();
		write_detent(4'd3);
		run_random(50);

		wait_idle();
		write_detent(4'($urandom_range(1, 14)));
		run_random(40);

		// Wait for every expected word, then a little longer to catch stray words.
		in_valid <= 1'b0;
		while (!sb.drained()) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.drained())
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/qdc_pkg.sv
rtl/core/qdc_front.sv
rtl/core/qdc_queue.sv
rtl/core/qdc_burst.sv
rtl/core/quadrature_detent_counter_lcd_unit.sv
tb/qdc_tb_pkg.sv
tb/quadrature_detent_counter_lcd_unit_tb.sv
